// ----- hw/rtl/abd_pkg.sv -----
// ----------------------------------------------------------------------------
// abd_pkg
// Shared types and constants for the block descrambler: the per-block work
// code, the transaction record that crosses the queue, and the register map.
// ----------------------------------------------------------------------------
package abd_pkg;

    // What the back end does with a block
    typedef enum logic [1:0] {
        OP_PASS = 2'd0,   // block goes out untouched
        OP_DES  = 2'd1,   // DES-like path
        OP_NAME = 2'd2,   // nibble swap, then DES-like path
        OP_SHUF = 2'd3    // byte shuffle with last-byte substitution
    } t_op;

    // One classified transaction, front to back
    typedef struct packed {
        logic [63:0] blk;
        logic        last;
        t_op         op;
    } t_item;

    // Register map (word index = paddr[3:2])
    localparam logic [1:0] REG_NAME_MODE = 2'd0;
    localparam logic [1:0] REG_TYPE_FLAG = 2'd1;
    localparam logic [1:0] REG_CYCLE_RAW = 2'd2;

    localparam int unsigned PADDR_W = 4;

    // Head of a run always takes the DES-like path
    localparam logic [4:0] HEAD_BLOCKS = 5'd20;

    // Shuffle counter ceiling
    localparam logic [2:0] SHUF_FULL = 3'd7;

endpackage

// ----- hw/rtl/abd_front.sv -----
// ----------------------------------------------------------------------------
// abd_front
// Register file, input handshake and block classification. Keeps the run
// counters and tags each accepted transaction with its work code.
// ----------------------------------------------------------------------------
module abd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // APB
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [abd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [63:0]                 i_block_in,
    input  logic                        i_last_block,
    // towards queue
    input  logic                        i_q_full,
    output logic                        o_push,
    output abd_pkg::t_item              o_item
);

    logic       r_name_mode, r_type_flag;
    logic [3:0] r_cycle_raw;
    logic [4:0] r_head, n_head;
    logic [4:0] r_period, n_period;
    logic [2:0] r_shuf, n_shuf;

    logic       wr_en;
    logic [1:0] reg_idx;
    logic       accept;
    logic       use_des;
    logic [4:0] cyc;
    abd_pkg::t_op op;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            abd_pkg::REG_NAME_MODE: prdata = {31'd0, r_name_mode};
            abd_pkg::REG_TYPE_FLAG: prdata = {31'd0, r_type_flag};
            abd_pkg::REG_CYCLE_RAW: prdata = {28'd0, r_cycle_raw};
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_mode <= 1'b0;
            r_type_flag <= 1'b0;
            r_cycle_raw <= 4'd0;
        end else if (wr_en) begin
            unique case (reg_idx)
                abd_pkg::REG_NAME_MODE: r_name_mode <= pwdata[0];
                abd_pkg::REG_TYPE_FLAG: r_type_flag <= pwdata[0];
                abd_pkg::REG_CYCLE_RAW: r_cycle_raw <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // adjusted cycle: 3 below 3, raw+1 below 5, raw+9 below 7, else raw+15
    always_comb begin
        priority if (r_cycle_raw < 4'd3) begin
            cyc = 5'd3;
        end else if (r_cycle_raw < 4'd5) begin
            cyc = {1'b0, r_cycle_raw} + 5'd1;
        end else if (r_cycle_raw < 4'd7) begin
            cyc = {1'b0, r_cycle_raw} + 5'd9;
        end else begin
            cyc = {1'b0, r_cycle_raw} + 5'd15;
        end
    end

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_head   = r_head;
        n_period = r_period;
        n_shuf   = r_shuf;
        use_des  = (r_head < abd_pkg::HEAD_BLOCKS) || (!r_type_flag && (r_period == 5'd0));
        op       = abd_pkg::OP_PASS;
        if (r_name_mode) begin
            op = abd_pkg::OP_NAME;
        end else begin
            if (use_des) begin
                op = abd_pkg::OP_DES;
            end else if ((r_shuf == abd_pkg::SHUF_FULL) && !r_type_flag) begin
                op     = abd_pkg::OP_SHUF;
                n_shuf = 3'd1;
            end else if (r_shuf != abd_pkg::SHUF_FULL) begin
                n_shuf = r_shuf + 3'd1;
            end
            if (r_head < abd_pkg::HEAD_BLOCKS) begin
                n_head = r_head + 5'd1;
            end
            if (({1'b0, r_period} + 6'd1) >= {1'b0, cyc}) begin
                n_period = 5'd0;
            end else begin
                n_period = r_period + 5'd1;
            end
        end
        // end of run
        if (i_last_block) begin
            n_head   = 5'd0;
            n_period = 5'd0;
            n_shuf   = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= 5'd0;
            r_period <= 5'd0;
            r_shuf   <= 3'd0;
        end else if (accept) begin
            r_head   <= n_head;
            r_period <= n_period;
            r_shuf   <= n_shuf;
        end
    end

    assign o_push      = accept;
    assign o_item.blk  = i_block_in;
    assign o_item.last = i_last_block;
    assign o_item.op   = op;

endmodule

// ----- hw/rtl/abd_queue.sv -----
// ----------------------------------------------------------------------------
// abd_queue
// Small circular queue of classified transactions between front and back.
// ----------------------------------------------------------------------------
module abd_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  abd_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_avail,
    output abd_pkg::t_item o_item
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    abd_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_avail = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/abd_back.sv -----
// ----------------------------------------------------------------------------
// abd_back
// Carries out the tagged work on the queue head and holds the result in the
// output register until the transaction is taken.
// ----------------------------------------------------------------------------
module abd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_avail,
    input  abd_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [63:0]    o_block_out,
    output logic           o_last_out
);

    localparam logic [6:0] IP_TAB [64] = '{
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
        7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
    };

    localparam logic [6:0] FP_TAB [64] = '{
        7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
        7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
        7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
        7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
        7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
        7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
        7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
        7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
    };

    localparam logic [5:0] P_TAB [32] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    localparam logic [7:0] SBOX [4][64] = '{
        '{
            8'hef, 8'h03, 8'h41, 8'hfd, 8'hd8, 8'h74, 8'h1e, 8'h47,
            8'h26, 8'hef, 8'hfb, 8'h22, 8'hb3, 8'hd8, 8'h84, 8'h1e,
            8'h39, 8'hac, 8'ha7, 8'h60, 8'h62, 8'hc1, 8'hcd, 8'hba,
            8'h5c, 8'h96, 8'h90, 8'h59, 8'h05, 8'h3b, 8'h7a, 8'h85,
            8'h40, 8'hfd, 8'h1e, 8'hc8, 8'he7, 8'h8a, 8'h8b, 8'h21,
            8'hda, 8'h43, 8'h64, 8'h9f, 8'h2d, 8'h14, 8'hb1, 8'h72,
            8'hf5, 8'h5b, 8'hc8, 8'hb6, 8'h9c, 8'h37, 8'h76, 8'hec,
            8'h39, 8'ha0, 8'ha3, 8'h05, 8'h52, 8'h6e, 8'h0f, 8'hd9
        },
        '{
            8'ha7, 8'hdd, 8'h0d, 8'h78, 8'h9e, 8'h0b, 8'he3, 8'h95,
            8'h60, 8'h36, 8'h36, 8'h4f, 8'hf9, 8'h60, 8'h5a, 8'ha3,
            8'h11, 8'h24, 8'hd2, 8'h87, 8'hc8, 8'h52, 8'h75, 8'hec,
            8'hbb, 8'hc1, 8'h4c, 8'hba, 8'h24, 8'hfe, 8'h8f, 8'h19,
            8'hda, 8'h13, 8'h66, 8'haf, 8'h49, 8'hd0, 8'h90, 8'h06,
            8'h8c, 8'h6a, 8'hfb, 8'h91, 8'h37, 8'h8d, 8'h0d, 8'h78,
            8'hbf, 8'h49, 8'h11, 8'hf4, 8'h23, 8'he5, 8'hce, 8'h3b,
            8'h55, 8'hbc, 8'ha2, 8'h57, 8'he8, 8'h22, 8'h74, 8'hce
        },
        '{
            8'h2c, 8'hea, 8'hc1, 8'hbf, 8'h4a, 8'h24, 8'h1f, 8'hc2,
            8'h79, 8'h47, 8'ha2, 8'h7c, 8'hb6, 8'hd9, 8'h68, 8'h15,
            8'h80, 8'h56, 8'h5d, 8'h01, 8'h33, 8'hfd, 8'hf4, 8'hae,
            8'hde, 8'h30, 8'h07, 8'h9b, 8'he5, 8'h83, 8'h9b, 8'h68,
            8'h49, 8'hb4, 8'h2e, 8'h83, 8'h1f, 8'hc2, 8'hb5, 8'h7c,
            8'ha2, 8'h19, 8'hd8, 8'he5, 8'h7c, 8'h2f, 8'h83, 8'hda,
            8'hf7, 8'h6b, 8'h90, 8'hfe, 8'hc4, 8'h01, 8'h5a, 8'h97,
            8'h61, 8'ha6, 8'h3d, 8'h40, 8'h0b, 8'h58, 8'he6, 8'h3d
        },
        '{
            8'h4d, 8'hd1, 8'hb2, 8'h0f, 8'h28, 8'hbd, 8'he4, 8'h78,
            8'hf6, 8'h4a, 8'h0f, 8'h93, 8'h8b, 8'h17, 8'hd1, 8'ha4,
            8'h3a, 8'hec, 8'hc9, 8'h35, 8'h93, 8'h56, 8'h7e, 8'hcb,
            8'h55, 8'h20, 8'ha0, 8'hfe, 8'h6c, 8'h89, 8'h17, 8'h62,
            8'h17, 8'h62, 8'h4b, 8'hb1, 8'hb4, 8'hde, 8'hd1, 8'h87,
            8'hc9, 8'h14, 8'h3c, 8'h4a, 8'h7e, 8'ha8, 8'he2, 8'h7d,
            8'ha0, 8'h9f, 8'hf6, 8'h5c, 8'h6a, 8'h09, 8'h8d, 8'hf0,
            8'h0f, 8'he3, 8'h53, 8'h25, 8'h95, 8'h36, 8'h28, 8'hcb
        }
    };

    // table entries count from 1, MSB first
    function automatic logic [63:0] perm_ip(input logic [63:0] x);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 64; i++) begin
            r[63-i] = x[6'(64 - int'(IP_TAB[i]))];
        end
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] x);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 64; i++) begin
            r[63-i] = x[6'(64 - int'(FP_TAB[i]))];
        end
        return r;
    endfunction

    function automatic logic [31:0] perm_p(input logic [31:0] x);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 32; i++) begin
            r[31-i] = x[5'(32 - int'(P_TAB[i]))];
        end
        return r;
    endfunction

    function automatic logic [63:0] des_path(input logic [63:0] x);
        logic [63:0] b;
        logic [7:0]  b4, b5, b6, b7;
        logic [5:0]  e [8];
        logic [31:0] f;
        b  = perm_ip(x);
        b4 = b[31:24];
        b5 = b[23:16];
        b6 = b[15:8];
        b7 = b[7:0];
        // expansion of the right half
        e[0] = {b7[0],   b4[7:3]};
        e[1] = {b4[4:0], b5[7]};
        e[2] = {b4[0],   b5[7:3]};
        e[3] = {b5[4:0], b6[7]};
        e[4] = {b5[0],   b6[7:3]};
        e[5] = {b6[4:0], b7[7]};
        e[6] = {b6[0],   b7[7:3]};
        e[7] = {b7[4:0], b4[7]};
        // high nibble from first box of a pair, low nibble from second
        f = '0;
        for (int k = 0; k < 4; k++) begin
            f[31-8*k -: 8] = {SBOX[k][e[2*k]][7:4], SBOX[k][e[2*k+1]][3:0]};
        end
        b[63:32] = b[63:32] ^ perm_p(f);
        return perm_fp(b);
    endfunction

    // paired substitution, an involution
    function automatic logic [7:0] subst(input logic [7:0] a);
        logic [7:0] r;
        unique case (a)
            8'h00:   r = 8'h2b;
            8'h2b:   r = 8'h00;
            8'h01:   r = 8'h68;
            8'h68:   r = 8'h01;
            8'h48:   r = 8'h77;
            8'h77:   r = 8'h48;
            8'h60:   r = 8'hff;
            8'hff:   r = 8'h60;
            8'h6c:   r = 8'h80;
            8'h80:   r = 8'h6c;
            8'hb9:   r = 8'hc0;
            8'hc0:   r = 8'hb9;
            8'heb:   r = 8'hfe;
            8'hfe:   r = 8'heb;
            default: r = a;
        endcase
        return r;
    endfunction

    // byte 0 at [63:56]; new order 3,4,6,0,1,2,5 then substituted byte 7
    function automatic logic [63:0] shuffle(input logic [63:0] x);
        return {x[39:32], x[31:24], x[15:8], x[63:56], x[55:48], x[47:40],
                x[23:16], subst(x[7:0])};
    endfunction

    function automatic logic [63:0] nib_swap(input logic [63:0] x);
        return ((x >> 4) & 64'h0f0f0f0f0f0f0f0f) | ((x << 4) & 64'hf0f0f0f0f0f0f0f0);
    endfunction

    logic        r_valid;
    logic [63:0] r_block;
    logic        r_last;
    logic [63:0] result;

    always_comb begin
        unique case (i_item.op)
            abd_pkg::OP_DES:  result = des_path(i_item.blk);
            abd_pkg::OP_NAME: result = des_path(nib_swap(i_item.blk));
            abd_pkg::OP_SHUF: result = shuffle(i_item.blk);
            default:          result = i_item.blk;
        endcase
    end

    assign o_pop = i_avail && (!r_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_block <= result;
            r_last  <= i_item.last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_block_out = r_block;
    assign o_last_out  = r_last;

endmodule

// ----- hw/rtl/archive_block_descrambler.sv -----
// ----------------------------------------------------------------------------
// archive_block_descrambler
// Single-round keyless DES-like descrambler for 8-byte archive blocks.
// ----------------------------------------------------------------------------
// One transaction per clock in steady state, while the consumer takes each
// result. On its way to the output a block passes through the queue entry,
// written with the classified transaction when its input is accepted, and
// then the output register, loaded from the queue head. The front end's run
// counters are updated once per accepted block, and the queue keeps taking
// blocks while a result is held for a stalled consumer, until QUEUE_DEPTH
// transactions sit behind the held one.
// Byte 0 of a block sits in bits 63:56 on both sides; o_last_out repeats the
// input's last flag, and the run counters clear after that block. The three
// registers (name_mode at 0x0, type_flag at 0x4, cycle_raw at 0x8) should be
// written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module archive_block_descrambler #(
    parameter int unsigned QUEUE_DEPTH = 2   // 2..16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // APB register port, zero wait states
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [abd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // scrambled block in
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [63:0]                 i_block_in,
    input  logic                        i_last_block,
    // descrambled block out
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [63:0]                 o_block_out,
    output logic                        o_last_out
);

    // front to queue
    logic           push;
    abd_pkg::t_item push_item;
    logic           q_full;

    // queue to back
    logic           pop;
    logic           q_avail;
    abd_pkg::t_item head_item;

    // Front: registers, run counters (head, period, shuffle) and the choice
    // of DES path, name path, shuffle or pass-through for each block.
    abd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_block_in   (i_block_in),
        .i_last_block (i_last_block),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_item       (push_item)
    );

    // Queue: decouples classification from the data path so that a stalled
    // consumer does not stop the producer straight away.
    abd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_avail (q_avail),
        .o_item  (head_item)
    );

    // Back: permutations, S-box round, shuffle; registered output.
    abd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avail     (q_avail),
        .i_item      (head_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_block_out (o_block_out),
        .o_last_out  (o_last_out)
    );

endmodule

// ----- hw/rtl/abd_sva.sv -----
// ----------------------------------------------------------------------------
// abd_sva
// Port-level checks for the block descrambler, bound to the top level.
// ----------------------------------------------------------------------------
module abd_sva (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        pready,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_block_out,
    input logic        o_last_out
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    // a held result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_block_out) && $stable(o_last_out))
        else $error("output payload changed while stalled");

    // queue only fills up behind a waiting result
    a_full_backs_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with nothing waiting at the output");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

    // zero wait-state register port
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind archive_block_descrambler abd_sva u_abd_sva (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .pready      (pready),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_block_out (o_block_out),
    .o_last_out  (o_last_out)
);
